### rtl/bitmap_block_inode_allocator_macros.svh
// Assertion macros for the allocator.
`ifndef BITMAP_BLOCK_INODE_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_INODE_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BBIA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BBIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BBIA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BBIA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/bbia_pkg.sv
`timescale 1ns / 1ps
package bbia_pkg;
  localparam int BLOCK_COUNT = 1024;
  localparam int INODE_COUNT = 64;
  localparam int WORD_BITS   = 32;
  localparam int BLOCK_WORDS = BLOCK_COUNT / WORD_BITS;
  localparam int INODE_WORDS = INODE_COUNT / WORD_BITS;
  localparam int IDX_W  = 10;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int BWA_W  = $clog2(BLOCK_WORDS);
  localparam int IWA_W  = $clog2(INODE_WORDS);
  localparam int FB_W   = 11;
  localparam int FI_W   = 7;
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    OP_ALLOC_BLOCK = 2'd0,
    OP_FREE_BLOCK  = 2'd1,
    OP_ALLOC_INODE = 2'd2,
    OP_FREE_INODE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic             in_range;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_CHECK, ST_WRITE, ST_DONE
  } state_t;
endpackage

### rtl/bbia_if.sv
`timescale 1ns / 1ps
interface bbia_in_if import bbia_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [IDX_W-1:0] index;
  modport source (output valid, operation, index, input ready);
  modport sink   (input valid, operation, index, output ready);
endinterface

interface bbia_out_if import bbia_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] granted_index;
  logic             found;
  logic [FB_W-1:0]  free_blocks;
  logic [FI_W-1:0]  free_inodes;
  modport source (output valid, granted_index, found, free_blocks, free_inodes,
                  input ready);
  modport sink   (input valid, granted_index, found, free_blocks, free_inodes,
                  output ready);
endinterface

### rtl/bitmap_block_inode_allocator.sv
`timescale 1ns / 1ps
// channel   | dir | payload
// in_ch     | in  | operation[1:0], index[9:0]
// out_ch    | out | granted_index[9:0], found, free_blocks[10:0], free_inodes[6:0]
// cfg       | in  | cfg_we, cfg_wdata[9:0] (reserved_blocks)
// One word at a time in the back end: allocations scan the bitmap word by word
// (up to 33 words for blocks, 2 for inodes).
// The block bitmap memory's single port sets the scan pace.
// A two-entry queue in front accepts words while the back end works.
// rst is synchronous; bitmaps read as free after reset with no clearing pass.
module bitmap_block_inode_allocator import bbia_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_wdata,
  bbia_in_if.sink          in_ch,
  bbia_out_if.source       out_ch
);
  logic [IDX_W-1:0] reserved;
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) reserved <= IDX_W'(16);
    else if (cfg_we) reserved <= cfg_wdata;
  end

  bbia_front u_front (.clk, .rst, .in_ch, .cmd, .cmd_valid, .cmd_pop);
  bbia_back  u_back  (.clk, .rst, .reserved, .cmd, .cmd_valid, .cmd_pop, .out_ch);
endmodule

### rtl/bbia_front.sv
`timescale 1ns / 1ps
module bbia_front import bbia_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bbia_in_if.sink    in_ch,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  logic       cmd_pop
);
  `include "bitmap_block_inode_allocator_macros.svh"
  cmd_t q [QDEPTH];
  logic [0:0] wptr, rptr;
  logic [1:0] cnt;
  cmd_t c_in;
  logic push;

  always_comb begin
    c_in.op  = op_t'(in_ch.operation);
    c_in.idx = in_ch.index;
    // inode frees beyond the table do nothing
    if (c_in.op == OP_FREE_INODE) c_in.in_range = (in_ch.index < IDX_W'(INODE_COUNT));
    else c_in.in_range = 1'b1;
  end

  assign in_ch.ready = (cnt != 2'(QDEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rptr];

  always_ff @(posedge clk) begin
    if (push) q[wptr] <= c_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; cnt <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (cmd_pop) rptr <= rptr + 1'b1;
      cnt <= cnt + 2'(push) - 2'(cmd_pop);
    end
  end

  `BBIA_ASSERT_IMPL(a_no_pop_empty, clk, rst, cmd_pop, cnt != 2'd0)
  `BBIA_ASSERT_IMPL(a_cnt_max, clk, rst, 1'b1, cnt <= 2'(QDEPTH))
  `BBIA_ASSERT_NEXT(a_push_cnt, clk, rst, push && !cmd_pop, cnt == $past(cnt) + 2'd1)
endmodule

### rtl/bbia_back.sv
`timescale 1ns / 1ps
module bbia_back import bbia_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] reserved,
  input  cmd_t             cmd,
  input  logic             cmd_valid,
  output logic             cmd_pop,
  bbia_out_if.source       out_ch
);
  `include "bitmap_block_inode_allocator_macros.svh"
  logic [WORD_BITS-1:0] bmem [BLOCK_WORDS];
  logic [BLOCK_WORDS-1:0] bvalid;
  logic [WORD_BITS-1:0] imap [INODE_WORDS];
  logic [WORD_BITS-1:0] rdata, rword;
  logic rvalid;

  state_t state, state_next;
  cmd_t cur;
  logic [IDX_W-1:0] pos;       // current candidate word base
  logic [IDX_W:0]   left;      // candidates remaining
  logic [IDX_W-1:0] gidx;
  logic             gfound;
  logic [FB_W-1:0]  used;
  logic [FI_W-1:0]  ifree;
  logic [BIT_W-1:0] hit_bit;
  logic             hit;
  logic [WORD_BITS-1:0] wdata;
  logic [BWA_W-1:0] waddr;
  logic             wen;
  logic [IDX_W:0]   cap;
  logic [BIT_W:0]   span;
  logic             do_alloc_b;

  assign waddr = pos[IDX_W-1:BIT_W];
  assign rword = rvalid ? rdata : '0;
  assign do_alloc_b = (cur.op == OP_ALLOC_BLOCK);

  // first free bit: for blocks in window [pos low bits .. min(end, left)] not below reserved; for inodes in the word
  always_comb begin
    logic [IDX_W-1:0] cand;
    hit = 1'b0; hit_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      cand = {pos[IDX_W-1:BIT_W], BIT_W'(b)};
      if (do_alloc_b) begin
        if (BIT_W'(b) >= pos[BIT_W-1:0] &&
            (11'(b) - 11'(pos[BIT_W-1:0])) < left &&
            cand >= reserved && !rword[b]) begin
          hit = 1'b1; hit_bit = BIT_W'(b);
        end
      end else if (!imap[pos[IWA_W+BIT_W-1:BIT_W]][b]) begin
        hit = 1'b1; hit_bit = BIT_W'(b);
      end
    end
  end

  always_comb begin
    span = (BIT_W+1)'(WORD_BITS) - {1'b0, pos[BIT_W-1:0]};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (cmd_valid) state_next = ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (!(cur.op == OP_ALLOC_BLOCK || cur.op == OP_ALLOC_INODE)) state_next = ST_WRITE;
        else if (hit) state_next = ST_WRITE;
        else if (do_alloc_b && left > 11'(span)) state_next = ST_READ;
        else if (!do_alloc_b && pos[IDX_W-1:BIT_W] != 5'(INODE_WORDS - 1))
          state_next = ST_READ;
        else state_next = ST_WRITE;
      end
      ST_WRITE: state_next = ST_DONE;
      ST_DONE:  if (out_ch.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = (state == ST_IDLE) && cmd_valid;
    out_ch.valid = (state == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // block word memory; unwritten words read as zero via bvalid
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rdata  <= bmem[waddr];
    end
    if (wen) bmem[waddr] <= wdata;
  end

  always_comb begin
    wen = 1'b0; wdata = rword;
    if (state == ST_WRITE && gfound && cur.op == OP_ALLOC_BLOCK) begin
      wen = 1'b1; wdata = rword | (WORD_BITS'(1) << gidx[BIT_W-1:0]);
    end else if (state == ST_WRITE && cur.op == OP_FREE_BLOCK) begin
      wen = 1'b1; wdata = rword & ~(WORD_BITS'(1) << cur.idx[BIT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= '0; rvalid <= 1'b0; used <= '0; ifree <= FI_W'(INODE_COUNT);
      for (int w = 0; w < INODE_WORDS; w++) imap[w] <= '0;
    end else begin
      if (state == ST_READ) rvalid <= bvalid[waddr];
      if (wen) bvalid[waddr] <= 1'b1;
      if (state == ST_WRITE) begin
        unique case (cur.op)
          OP_ALLOC_BLOCK: if (gfound && used != FB_W'(BLOCK_COUNT)) used <= used + 1'b1;
          OP_FREE_BLOCK:  if (used != '0) used <= used - 1'b1;
          OP_ALLOC_INODE: if (gfound) begin
            imap[gidx[IWA_W+BIT_W-1:BIT_W]][gidx[BIT_W-1:0]] <= 1'b1;
            if (ifree != '0) ifree <= ifree - 1'b1;
          end
          OP_FREE_INODE: if (cur.in_range) begin
            imap[cur.idx[IWA_W+BIT_W-1:BIT_W]][cur.idx[BIT_W-1:0]] <= 1'b0;
            if (ifree != FI_W'(INODE_COUNT)) ifree <= ifree + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd; gfound <= 1'b0; gidx <= '0;
      left <= (IDX_W+1)'(BLOCK_COUNT - 1);
      if (cmd.op == OP_ALLOC_BLOCK) pos <= cmd.idx + 1'b1;
      else if (cmd.op == OP_FREE_BLOCK) pos <= cmd.idx;
      else pos <= '0;
    end else if (state == ST_CHECK) begin
      if (cur.op == OP_FREE_BLOCK || cur.op == OP_FREE_INODE) begin
        gfound <= cur.in_range;
      end else if (hit) begin
        gfound <= 1'b1;
        gidx <= {pos[IDX_W-1:BIT_W], hit_bit};
      end else if (do_alloc_b) begin
        left <= (left > 11'(span)) ? left - 11'(span) : '0;
        pos  <= {pos[IDX_W-1:BIT_W] + 1'b1, BIT_W'(0)};
      end else begin
        pos  <= {pos[IDX_W-1:BIT_W] + 1'b1, BIT_W'(0)};
      end
    end
  end

  always_comb begin
    cap = (IDX_W+1)'(BLOCK_COUNT) - {1'b0, reserved};
    out_ch.granted_index = gidx;
    out_ch.found = gfound;
    out_ch.free_blocks = (cap > used) ? cap - used : '0;
    out_ch.free_inodes = ifree;
  end

  `BBIA_ASSERT_IMPL(a_pop_idle, clk, rst, cmd_pop, state == ST_IDLE)
  `BBIA_ASSERT_IMPL(a_ifree_cap, clk, rst, 1'b1, ifree <= FI_W'(INODE_COUNT))
  `BBIA_ASSERT_NEXT(a_done_hold, clk, rst, out_ch.valid && !out_ch.ready,
                    out_ch.valid && $stable(gidx))
endmodule

### test/tb.sv
`timescale 1ns / 1ps
module tb;
  import bbia_pkg::*;

  // One request word: operation plus hint/index.
  typedef struct {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } req_t;

  // One response word as the allocator should report it.
  typedef struct {
    logic [IDX_W-1:0] granted_index;
    logic             found;
    logic [FB_W-1:0]  free_blocks;
    logic [FI_W-1:0]  free_inodes;
  } resp_t;

  localparam int GAP_MAX    = 14;
  localparam int STALL_LIM  = 5000;  // idle cycles before giving up
  localparam int DRAIN_WAIT = 80;    // outlasts the worst block allocation

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_wdata = '0;

  bbia_in_if  in_if ();
  bbia_out_if out_if ();

  bitmap_block_inode_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  always #4 clk = ~clk;

  // Shadow copy of the allocator state.
  bit          blk_used [BLOCK_COUNT];
  bit          ino_used [INODE_COUNT];
  int unsigned used_blocks;
  int unsigned free_inode_cnt;
  int unsigned reserved_cfg;

  req_t  req_q [$];    // words waiting to be driven
  resp_t resp_q [$];   // responses still owed by the block
  int    errs;
  bit    burst_in, burst_out;  // stretches with no idling at all

  // Free block report: capacity minus used, floored at zero.
  function automatic logic [FB_W-1:0] free_block_report();
    int unsigned cap;
    if (reserved_cfg >= BLOCK_COUNT) return '0;
    cap = BLOCK_COUNT - reserved_cfg;
    return (cap > used_blocks) ? FB_W'(cap - used_blocks) : '0;
  endfunction

  // Apply one operation to the shadow state and return the response.
  function automatic resp_t alloc_predict(req_t r);
    resp_t       rs;
    int unsigned cand;
    rs.granted_index = '0;
    rs.found = 1'b0;
    case (r.op)
      OP_ALLOC_BLOCK: begin
        // next-fit from hint+1, wrapping; the hint itself is never a candidate
        for (int k = 1; k < BLOCK_COUNT; k++) begin
          cand = (int'(r.idx) + k) % BLOCK_COUNT;
          if (cand < reserved_cfg) continue;
          if (!blk_used[cand]) begin
            blk_used[cand] = 1'b1;
            if (used_blocks < BLOCK_COUNT) used_blocks++;
            rs.granted_index = IDX_W'(cand);
            rs.found = 1'b1;
            break;
          end
        end
      end
      OP_FREE_BLOCK: begin
        // every 10-bit index is on the disk; reserved blocks free normally
        blk_used[r.idx] = 1'b0;
        if (used_blocks > 0) used_blocks--;
        rs.found = 1'b1;
      end
      OP_ALLOC_INODE: begin
        for (int i = 0; i < INODE_COUNT; i++) begin
          if (!ino_used[i]) begin
            ino_used[i] = 1'b1;
            if (free_inode_cnt > 0) free_inode_cnt--;
            rs.granted_index = IDX_W'(i);
            rs.found = 1'b1;
            break;
          end
        end
      end
      default: begin
        // out-of-range inode frees are dropped with found low
        if (r.idx < INODE_COUNT) begin
          ino_used[r.idx] = 1'b0;
          if (free_inode_cnt < INODE_COUNT) free_inode_cnt++;
          rs.found = 1'b1;
        end
      end
    endcase
    rs.free_blocks = free_block_report();
    rs.free_inodes = FI_W'(free_inode_cnt);
    return rs;
  endfunction

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  // Request driver: holds a word until taken, then waits its drawn gap.
  int gap_cnt;
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid     <= 1'b0;
      in_if.operation <= '0;
      in_if.index     <= '0;
      gap_cnt = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        resp_q.push_back(alloc_predict('{op_t'(in_if.operation), in_if.index}));
        if ($urandom_range(0, 59) == 0) burst_in = ~burst_in;
        gap_cnt = draw_gap(burst_in);
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_if.valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          req_t r;
          r = req_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.operation <= r.op;
          in_if.index     <= r.idx;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random back-pressure.
  int stall_cnt;
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (resp_q.size() == 0) begin
          $error("unexpected response word: granted_index %0d", out_if.granted_index);
          errs++;
        end else begin
          resp_t e;
          e = resp_q.pop_front();
          if (out_if.granted_index !== e.granted_index) begin
            $error("granted_index: expected %0d, got %0d", e.granted_index,
                   out_if.granted_index);
            errs++;
          end
          if (out_if.found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, out_if.found);
            errs++;
          end
          if (out_if.free_blocks !== e.free_blocks) begin
            $error("free_blocks: expected %0d, got %0d", e.free_blocks,
                   out_if.free_blocks);
            errs++;
          end
          if (out_if.free_inodes !== e.free_inodes) begin
            $error("free_inodes: expected %0d, got %0d", e.free_inodes,
                   out_if.free_inodes);
            errs++;
          end
        end
        if ($urandom_range(0, 59) == 0) burst_out = ~burst_out;
        stall_cnt = draw_gap(burst_out);
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles with no word moving on either side.
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIM) begin
      $display("*** FAILED ***");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic push_req(op_t op, int unsigned idx);
    req_q.push_back('{op, IDX_W'(idx)});
  endtask

  // Random words; pct_ab / pct_fb steer the mix, the rest are inode ops.
  task automatic push_random(int n, int pct_ab, int pct_fb);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < pct_ab)
        push_req(OP_ALLOC_BLOCK, $urandom_range(0, BLOCK_COUNT - 1));
      else if (r < pct_ab + pct_fb)
        push_req(OP_FREE_BLOCK, $urandom_range(0, BLOCK_COUNT - 1));
      else if ($urandom_range(0, 1))
        push_req(OP_ALLOC_INODE, $urandom_range(0, BLOCK_COUNT - 1));
      else if ($urandom_range(0, 9) < 7)
        push_req(OP_FREE_INODE, $urandom_range(0, INODE_COUNT - 1));
      else
        push_req(OP_FREE_INODE, $urandom_range(INODE_COUNT, BLOCK_COUNT - 1));
    end
  endtask

  // Let the queued words drain and every response come back.
  // Sampled on the falling edge so the driver's updates have settled.
  task automatic drain();
    do @(negedge clk);
    while (req_q.size() != 0 || in_if.valid || resp_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic set_reserved(int unsigned v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= IDX_W'(v);
    reserved_cfg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    errs = 0;
    burst_in = 0;
    burst_out = 0;
    used_blocks = 0;
    free_inode_cnt = INODE_COUNT;
    reserved_cfg = 16;
    foreach (blk_used[i]) blk_used[i] = 1'b0;
    foreach (ino_used[i]) ino_used[i] = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = '0;
    in_if.index = '0;
    out_if.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset reserve of 16, edge hints, double frees, range checks.
    push_req(OP_ALLOC_BLOCK, 0);      // skips reserved, lands on 16
    push_req(OP_ALLOC_BLOCK, 1023);   // wraps past the top
    push_req(OP_ALLOC_BLOCK, 15);
    push_req(OP_ALLOC_BLOCK, 16);     // hint itself never examined
    push_req(OP_FREE_BLOCK, 0);       // reserved block frees normally
    push_req(OP_FREE_BLOCK, 1023);
    push_req(OP_FREE_BLOCK, 1023);    // already free
    push_req(OP_FREE_BLOCK, 17);
    push_req(OP_FREE_BLOCK, 16);
    push_req(OP_FREE_BLOCK, 16);      // counter saturates at zero used
    push_req(OP_ALLOC_INODE, 0);
    push_req(OP_ALLOC_INODE, 1023);   // index ignored
    push_req(OP_ALLOC_INODE, 512);
    push_req(OP_FREE_INODE, 63);
    push_req(OP_FREE_INODE, 64);      // out of range
    push_req(OP_FREE_INODE, 1023);
    push_req(OP_FREE_INODE, 0);
    push_req(OP_FREE_INODE, 0);       // double free still counts; count reaches capacity
    push_req(OP_ALLOC_BLOCK, 1022);
    drain();

    // Tiny disk: fills fast, then allocations miss.
    set_reserved(1000);
    push_random(150, 70, 10);
    drain();

    // No reserve: wrap through block 0.
    set_reserved(0);
    push_req(OP_ALLOC_BLOCK, 1023);
    push_random(300, 45, 25);
    drain();

    // Maximum reserve: only block 1023 can ever be granted.
    set_reserved(1023);
    push_req(OP_ALLOC_BLOCK, 1023);
    push_req(OP_ALLOC_BLOCK, 1022);
    push_random(100, 50, 20);
    drain();

    set_reserved($urandom_range(0, 1023));
    push_random(450, 60, 15);
    drain();

    set_reserved(16);
    push_random(480, 40, 30);
    drain();

    if (resp_q.size() != 0) errs++;
    if (errs == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
